>>> rtl/core/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// Shared beat types and codes of the shortest common supersequence engine.
// ----------------------------------------------------------------------------
package scs_pkg;

	localparam int SYM_W = 8;
	localparam int LEN_W = 7;

	localparam logic SEL_FIRST  = 1'b0;
	localparam logic SEL_SECOND = 1'b1;

	typedef struct packed {
		logic             func;
		logic [SYM_W-1:0] symbol;
		logic             no_symbol;
		logic             last;
	} item_t;

	typedef struct packed {
		logic [SYM_W-1:0] out_symbol;
		logic             out_last;
		logic [LEN_W-1:0] total_length;
		logic             overflow;
	} result_t;

	typedef enum logic [1:0] {
		DIR_DIAG = 2'd0,
		DIR_UP   = 2'd1,
		DIR_LEFT = 2'd2
	} dir_t;

endpackage

>>> rtl/core/scs_str_mem.sv
// ----------------------------------------------------------------------------
// scs_str_mem
// Storage of both input strings, one write port, one registered read per string.
// ----------------------------------------------------------------------------
module scs_str_mem #(
	parameter int MAX_LEN = 32,
	localparam int LW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
	input  logic                      clk,
	input  logic                      we_a,
	input  logic                      we_b,
	input  logic [LW-1:0]             waddr,
	input  logic [scs_pkg::SYM_W-1:0] wdata,
	input  logic [LW-1:0]             raddr_a,
	input  logic [LW-1:0]             raddr_b,
	output logic [scs_pkg::SYM_W-1:0] a_sym,
	output logic [scs_pkg::SYM_W-1:0] b_sym
);

	logic [scs_pkg::SYM_W-1:0] first_mem  [MAX_LEN];
	logic [scs_pkg::SYM_W-1:0] second_mem [MAX_LEN];

	always_ff @(posedge clk) begin
		if (we_a) begin
			first_mem[waddr] <= wdata;
		end
		if (we_b) begin
			second_mem[waddr] <= wdata;
		end
		a_sym <= first_mem[raddr_a];
		b_sym <= second_mem[raddr_b];
	end

endmodule

>>> rtl/core/scs_fill.sv
// ----------------------------------------------------------------------------
// scs_fill
// Cost table fill: one cell per cycle within a row over a rolling cost row memory,
// an idle F_ROW state between rows, direction of every cell sent out for storage.
// ----------------------------------------------------------------------------
module scs_fill #(
	parameter int MAX_LEN = 32,
	localparam int LW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
	localparam int CW = $clog2(MAX_LEN + 1),
	localparam int NW = $clog2(2 * MAX_LEN + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [CW-1:0]             len_a,
	input  logic [CW-1:0]             len_b,
	input  logic [scs_pkg::SYM_W-1:0] a_sym,
	input  logic [scs_pkg::SYM_W-1:0] b_sym,
	output logic [LW-1:0]             row_addr,
	output logic [LW-1:0]             col_addr,
	output logic                      dir_we,
	output logic [LW-1:0]             dir_row,
	output logic [LW-1:0]             dir_col,
	output scs_pkg::dir_t             dir_val,
	output logic                      done
);

	typedef enum logic [3:0] {
		F_IDLE  = 4'b0001,
		F_ROW   = 4'b0010,
		F_CELL  = 4'b0100,
		F_DRAIN = 4'b1000
	} fill_state_t;

	fill_state_t   state_q;
	logic [CW-1:0] r_q;
	logic [CW-1:0] c_q;
	logic          valid_s1;
	logic [CW-1:0] r_s1;
	logic [CW-1:0] c_s1;
	logic [NW-1:0] cost_rd_s1;
	logic [NW-1:0] left_q;
	logic [NW-1:0] diag_q;
	logic [NW-1:0] cost_mem [MAX_LEN];

	logic [NW-1:0] up;
	logic [NW-1:0] left;
	logic [NW-1:0] diag;
	logic [NW-1:0] cost_new;

	assign row_addr = LW'(r_q - CW'(1));
	assign col_addr = LW'(c_q - CW'(1));
	assign done     = (state_q == F_DRAIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			r_q      <= '0;
			c_q      <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == F_CELL);
			unique case (state_q)
				F_IDLE: begin
					if (go) begin
						r_q <= CW'(1);
						if (len_a == '0 || len_b == '0) begin
							state_q <= F_DRAIN;
						end else begin
							state_q <= F_ROW;
						end
					end
				end
				F_ROW: begin
					c_q     <= CW'(1);
					state_q <= F_CELL;
				end
				F_CELL: begin
					if (c_q == len_b) begin
						if (r_q == len_a) begin
							state_q <= F_DRAIN;
						end else begin
							r_q     <= r_q + CW'(1);
							state_q <= F_ROW;
						end
					end else begin
						c_q <= c_q + CW'(1);
					end
				end
				F_DRAIN: begin
					state_q <= F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// first row sees the all-ascending initial row, first column its row number
	always_comb begin
		up   = (r_s1 == CW'(1)) ? NW'(c_s1) : cost_rd_s1;
		left = (c_s1 == CW'(1)) ? NW'(r_s1) : left_q;
		diag = (c_s1 == CW'(1)) ? NW'(r_s1 - CW'(1)) : diag_q;
		if (a_sym == b_sym) begin
			cost_new = diag + NW'(1);
			dir_val  = scs_pkg::DIR_DIAG;
		end else if (up <= left) begin
			cost_new = up + NW'(1);
			dir_val  = scs_pkg::DIR_UP;
		end else begin
			cost_new = left + NW'(1);
			dir_val  = scs_pkg::DIR_LEFT;
		end
	end

	always_ff @(posedge clk) begin
		r_s1       <= r_q;
		c_s1       <= c_q;
		cost_rd_s1 <= cost_mem[col_addr];
		if (valid_s1) begin
			cost_mem[LW'(c_s1 - CW'(1))] <= cost_new;
			left_q <= cost_new;
			diag_q <= up;
		end
	end

	assign dir_we  = valid_s1;
	assign dir_row = LW'(r_s1 - CW'(1));
	assign dir_col = LW'(c_s1 - CW'(1));

endmodule

>>> rtl/core/scs_trace.sv
// ----------------------------------------------------------------------------
// scs_trace
// Direction table, walk back from the string ends into a reversal buffer,
// then read the buffer out backwards as result beats.
// ----------------------------------------------------------------------------
module scs_trace #(
	parameter int MAX_LEN = 32,
	localparam int LW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
	localparam int CW = $clog2(MAX_LEN + 1),
	localparam int NW = $clog2(2 * MAX_LEN + 1),
	localparam int RW = $clog2(2 * MAX_LEN)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [CW-1:0]             len_a,
	input  logic [CW-1:0]             len_b,
	input  logic                      overflow,
	input  logic                      dir_we,
	input  logic [LW-1:0]             dir_row,
	input  logic [LW-1:0]             dir_col,
	input  scs_pkg::dir_t             dir_val,
	input  logic [scs_pkg::SYM_W-1:0] a_sym,
	input  logic [scs_pkg::SYM_W-1:0] b_sym,
	output logic [LW-1:0]             row_addr,
	output logic [LW-1:0]             col_addr,
	output scs_pkg::result_t          result,
	output logic                      strobe,
	output logic                      done
);

	localparam int TOT_W = scs_pkg::LEN_W;

	typedef enum logic [4:0] {
		T_IDLE = 5'b00001,
		T_RD   = 5'b00010,
		T_DEC  = 5'b00100,
		T_EMIT = 5'b01000,
		T_END  = 5'b10000
	} trace_state_t;

	trace_state_t              state_q;
	logic [CW-1:0]             r_q;
	logic [CW-1:0]             c_q;
	logic [NW-1:0]             n_q;
	logic [RW-1:0]             p_q;
	logic                      valid_s1;
	logic                      last_s1;
	logic [1:0]                dir_mem [1 << (2 * LW)];
	scs_pkg::dir_t             dir_rd;
	logic [scs_pkg::SYM_W-1:0] rev_mem [2 * MAX_LEN];
	logic [scs_pkg::SYM_W-1:0] rev_rd;

	logic                      take_b;
	logic                      step_r;
	logic                      step_c;
	logic [scs_pkg::SYM_W-1:0] sym;

	assign row_addr = LW'(r_q - CW'(1));
	assign col_addr = LW'(c_q - CW'(1));
	assign done     = (state_q == T_END);

	always_comb begin
		take_b = 1'b0;
		step_r = 1'b0;
		step_c = 1'b0;
		if (r_q != '0 && c_q != '0) begin
			unique case (dir_rd)
				scs_pkg::DIR_LEFT: begin
					take_b = 1'b1;
					step_c = 1'b1;
				end
				scs_pkg::DIR_UP: begin
					step_r = 1'b1;
				end
				default: begin
					step_r = 1'b1;
					step_c = 1'b1;
				end
			endcase
		end else if (r_q != '0) begin
			step_r = 1'b1;
		end else begin
			take_b = 1'b1;
			step_c = 1'b1;
		end
		sym = take_b ? b_sym : a_sym;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= T_IDLE;
			r_q      <= '0;
			c_q      <= '0;
			n_q      <= '0;
			p_q      <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == T_EMIT);
			unique case (state_q)
				T_IDLE: begin
					if (go) begin
						r_q     <= len_a;
						c_q     <= len_b;
						n_q     <= '0;
						state_q <= T_RD;
					end
				end
				T_RD: begin
					if (r_q == '0 && c_q == '0) begin
						p_q     <= RW'(n_q - NW'(1));
						state_q <= (n_q == '0) ? T_END : T_EMIT;
					end else begin
						state_q <= T_DEC;
					end
				end
				T_DEC: begin
					if (step_r) begin
						r_q <= r_q - CW'(1);
					end
					if (step_c) begin
						c_q <= c_q - CW'(1);
					end
					n_q     <= n_q + NW'(1);
					state_q <= T_RD;
				end
				T_EMIT: begin
					if (p_q == '0) begin
						state_q <= T_END;
					end else begin
						p_q <= p_q - RW'(1);
					end
				end
				T_END: begin
					state_q <= T_IDLE;
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_mem[{dir_row, dir_col}] <= dir_val;
		end
		dir_rd <= scs_pkg::dir_t'(dir_mem[{row_addr, col_addr}]);
		if (state_q == T_DEC) begin
			rev_mem[RW'(n_q)] <= sym;
		end
		rev_rd  <= rev_mem[p_q];
		last_s1 <= (p_q == '0);
	end

	assign strobe              = valid_s1;
	assign result.out_symbol   = rev_rd;
	assign result.out_last     = last_s1;
	assign result.total_length = TOT_W'(n_q);
	assign result.overflow     = overflow;

`ifndef SYNTHESIS
	a_strobe_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ($past(state_q) == T_EMIT))
		else $error("result beat outside read-out");
	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_EMIT) |-> (r_q == '0 && c_q == '0))
		else $error("read-out started before walk reached origin");
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_DEC) |-> (n_q < NW'(2 * MAX_LEN)))
		else $error("reversal buffer overrun");
`endif

endmodule

>>> rtl/core/shortest_common_supersequence.sv
// ----------------------------------------------------------------------------
// shortest_common_supersequence: loads two strings, fills, walks back, emits.
// Load: one symbol beat per cycle. After the closing beat of the second string
// busy stays high through the row fill (none when either string is empty), the
// walk steps (T_RD then T_DEC each) and the read-out, bound by the single cost
// row and direction memory ports. Results come one per cycle, one beat per
// supersequence symbol; async reset returns to loading.
// ----------------------------------------------------------------------------
module shortest_common_supersequence #(
	parameter int MAX_LEN = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  scs_pkg::item_t    item,
	output logic              busy,
	output scs_pkg::result_t  result,
	output logic              strobe
);

	localparam int LW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW = $clog2(MAX_LEN + 1);

	typedef enum logic [3:0] {
		S_LOAD_A = 4'b0001,
		S_LOAD_B = 4'b0010,
		S_FILL   = 4'b0100,
		S_TRACE  = 4'b1000
	} top_state_t;

	top_state_t    state_q;
	logic [CW-1:0] len_a_q;
	logic [CW-1:0] len_b_q;
	logic          overflow_q;

	logic                      accept;
	logic                      take_a;
	logic                      take_b;
	logic                      store;
	logic                      room_a;
	logic                      room_b;
	logic                      we_a;
	logic                      we_b;
	logic [LW-1:0]             waddr;
	logic                      fill_go;
	logic                      trace_go;
	logic                      fill_done;
	logic                      trace_done;
	logic [LW-1:0]             fill_row;
	logic [LW-1:0]             fill_col;
	logic [LW-1:0]             trace_row;
	logic [LW-1:0]             trace_col;
	logic [LW-1:0]             raddr_a;
	logic [LW-1:0]             raddr_b;
	logic [scs_pkg::SYM_W-1:0] a_sym;
	logic [scs_pkg::SYM_W-1:0] b_sym;
	logic                      dir_we;
	logic [LW-1:0]             dir_row;
	logic [LW-1:0]             dir_col;
	scs_pkg::dir_t             dir_val;

	assign busy    = (state_q == S_FILL) || (state_q == S_TRACE);
	assign accept  = start && !busy;
	// drop beats whose selector does not name the string being loaded
	assign take_a  = accept && (state_q == S_LOAD_A) && (item.func == scs_pkg::SEL_FIRST);
	assign take_b  = accept && (state_q == S_LOAD_B) && (item.func == scs_pkg::SEL_SECOND);
	assign store   = !item.no_symbol;
	assign room_a  = (len_a_q < CW'(MAX_LEN));
	assign room_b  = (len_b_q < CW'(MAX_LEN));
	assign we_a    = take_a && store && room_a;
	assign we_b    = take_b && store && room_b;
	assign waddr   = take_a ? len_a_q[LW-1:0] : len_b_q[LW-1:0];
	assign fill_go = take_b && item.last;
	assign trace_go = (state_q == S_FILL) && fill_done;
	assign raddr_a = (state_q == S_FILL) ? fill_row : trace_row;
	assign raddr_b = (state_q == S_FILL) ? fill_col : trace_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD_A;
			len_a_q    <= '0;
			len_b_q    <= '0;
			overflow_q <= 1'b0;
		end else begin
			if (we_a) begin
				len_a_q <= len_a_q + CW'(1);
			end
			if (we_b) begin
				len_b_q <= len_b_q + CW'(1);
			end
			if ((take_a && store && !room_a) || (take_b && store && !room_b)) begin
				overflow_q <= 1'b1;
			end
			unique case (state_q)
				S_LOAD_A: begin
					if (take_a && item.last) begin
						state_q <= S_LOAD_B;
					end
				end
				S_LOAD_B: begin
					if (fill_go) begin
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					if (fill_done) begin
						state_q <= S_TRACE;
					end
				end
				S_TRACE: begin
					if (trace_done) begin
						len_a_q    <= '0;
						len_b_q    <= '0;
						overflow_q <= 1'b0;
						state_q    <= S_LOAD_A;
					end
				end
				default: begin
					state_q <= S_LOAD_A;
				end
			endcase
		end
	end

	scs_str_mem #(
		.MAX_LEN (MAX_LEN)
	) u_str_mem (
		.clk     (clk),
		.we_a    (we_a),
		.we_b    (we_b),
		.waddr   (waddr),
		.wdata   (item.symbol),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.a_sym   (a_sym),
		.b_sym   (b_sym)
	);

	scs_fill #(
		.MAX_LEN (MAX_LEN)
	) u_fill (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (fill_go),
		.len_a    (len_a_q),
		.len_b    (we_b ? len_b_q + CW'(1) : len_b_q),
		.a_sym    (a_sym),
		.b_sym    (b_sym),
		.row_addr (fill_row),
		.col_addr (fill_col),
		.dir_we   (dir_we),
		.dir_row  (dir_row),
		.dir_col  (dir_col),
		.dir_val  (dir_val),
		.done     (fill_done)
	);

	scs_trace #(
		.MAX_LEN (MAX_LEN)
	) u_trace (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (trace_go),
		.len_a    (len_a_q),
		.len_b    (len_b_q),
		.overflow (overflow_q),
		.dir_we   (dir_we),
		.dir_row  (dir_row),
		.dir_col  (dir_col),
		.dir_val  (dir_val),
		.a_sym    (a_sym),
		.b_sym    (b_sym),
		.row_addr (trace_row),
		.col_addr (trace_col),
		.result   (result),
		.strobe   (strobe),
		.done     (trace_done)
	);

`ifndef SYNTHESIS
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result beat while idle");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.out_last) |=> !strobe)
		else $error("result beat after final beat");
	a_load_a_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD_A) |-> (len_b_q == '0))
		else $error("second string not cleared");
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(fill_go))
		else $error("busy raised without closing beat");
`endif

endmodule
